### src/tftpce_pkg.sv
// shared types and constants of the tftp client transfer engine
package tftpce_pkg;

   localparam int CMD_W   = 2;
   localparam int PLEN_W  = 11;
   localparam int WORD_W  = 16;
   localparam int CHUNK_W = 10;
   localparam int KIND_W  = 3;
   localparam int STAT_W  = 3;
   localparam int TMO_W   = 4;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = CMD_W;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = KIND_W;

   localparam logic [CHUNK_W-1:0] BLOCK_FULL  = 10'd512;
   localparam logic [PLEN_W-1:0]  HEADER_LEN  = 11'd4;
   localparam logic [CHUNK_W-1:0] STORE_MAX   = 10'd1023;
   localparam logic [TMO_W-1:0]   TMO_DEFAULT = 4'd4;

   localparam logic [WORD_W-1:0] OP_DATA    = 16'd3;
   localparam logic [WORD_W-1:0] OP_ACK     = 16'd4;
   localparam logic [WORD_W-1:0] OP_SRV_ERR = 16'd5;

   typedef enum logic [CMD_W-1:0] {
      CMD_GET     = 2'd0,
      CMD_PUT     = 2'd1,
      CMD_PACKET  = 2'd2,
      CMD_TIMEOUT = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_GET  = 2'd1,
      MODE_PUT  = 2'd2
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      SK_NONE   = 3'd0,
      SK_RRQ    = 3'd1,
      SK_WRQ    = 3'd2,
      SK_DATA   = 3'd3,
      SK_ACK    = 3'd4,
      SK_RESEND = 3'd5
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_IDLE = 3'd0,
      ST_BUSY = 3'd1,
      ST_DONE = 3'd2,
      ST_SERR = 3'd3,
      ST_TOUT = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type              command;
      logic [PLEN_W-1:0]    packet_length;
      logic [WORD_W-1:0]    packet_opcode;
      logic [WORD_W-1:0]    packet_block;
      logic [CHUNK_W-1:0]   next_chunk_bytes;
   } req_type;

   typedef struct packed {
      kind_type             send_kind;
      logic [WORD_W-1:0]    send_block;
      logic [CHUNK_W-1:0]   send_bytes;
      logic [CHUNK_W-1:0]   store_bytes;
      status_type           status;
      logic                 ignored;
      logic [WORD_W-1:0]    server_error_code;
   } rsp_type;

endpackage

### src/tftpce_in_reg.sv
// input register holding one accepted request until the engine takes it
module tftpce_in_reg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tftpce_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [tftpce_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                              out_free,
   output logic                              take,
   output tftpce_pkg::req_type               hold_req
);
   import tftpce_pkg::*;

   logic    valid_ff, valid_in;
   req_type req_ff, req_in;
   logic    accept;

   assign take       = valid_ff && out_free;
   assign req_tready = !valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign hold_req   = req_ff;

   always_comb begin
      valid_in = valid_ff;
      req_in   = req_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in                = 1'b1;
         req_in.command          = cmd_type'(req_tuser[CMD_W-1:0]);
         req_in.packet_length    = req_tdata[10:0];
         req_in.packet_opcode    = req_tdata[26:11];
         req_in.packet_block     = req_tdata[42:27];
         req_in.next_chunk_bytes = req_tdata[52:43];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_in;
   end

endmodule

### src/tftpce_engine.sv
// transfer state and per-request decision logic
module tftpce_engine #(
   parameter int MAX_PACKET = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  tftpce_pkg::req_type           req,
   input  logic [tftpce_pkg::TMO_W-1:0]  max_timeouts,
   output tftpce_pkg::rsp_type           rsp
);
   import tftpce_pkg::*;

   localparam int MaxW = $clog2(MAX_PACKET + 1);
   localparam int LenW = (MaxW > PLEN_W) ? MaxW : PLEN_W;

   mode_type            mode_ff, mode_in;
   logic [WORD_W-1:0]   exp_blk_ff, exp_blk_in;
   logic [TMO_W-1:0]    tmo_cnt_ff, tmo_cnt_in;
   logic [CHUNK_W-1:0]  last_chunk_ff, last_chunk_in;

   logic [LenW-1:0]     len_wide;
   logic [PLEN_W-1:0]   plen;
   logic [PLEN_W-1:0]   pay;
   logic [CHUNK_W-1:0]  chunk;
   logic [TMO_W-1:0]    tmo_inc;
   logic [WORD_W-1:0]   exp_next;

   always_comb begin
      len_wide = LenW'(req.packet_length);
      if (len_wide > LenW'(MAX_PACKET)) begin
         len_wide = LenW'(MAX_PACKET);
      end
      plen     = len_wide[PLEN_W-1:0];
      pay      = plen - HEADER_LEN;
      chunk    = (req.next_chunk_bytes > BLOCK_FULL) ? BLOCK_FULL : req.next_chunk_bytes;
      tmo_inc  = tmo_cnt_ff + TMO_W'(1);
      exp_next = exp_blk_ff + WORD_W'(1);
   end

   always_comb begin
      mode_in       = mode_ff;
      exp_blk_in    = exp_blk_ff;
      tmo_cnt_in    = tmo_cnt_ff;
      last_chunk_in = last_chunk_ff;
      rsp           = '0;
      rsp.send_kind = SK_NONE;
      rsp.status    = ST_BUSY;

      if (req.command == CMD_GET) begin
         mode_in       = MODE_GET;
         exp_blk_in    = WORD_W'(1);
         tmo_cnt_in    = '0;
         rsp.send_kind = SK_RRQ;
      end else if (req.command == CMD_PUT) begin
         mode_in       = MODE_PUT;
         exp_blk_in    = '0;
         last_chunk_in = BLOCK_FULL;
         tmo_cnt_in    = '0;
         rsp.send_kind = SK_WRQ;
      end else if (mode_ff != MODE_GET && mode_ff != MODE_PUT) begin
         mode_in     = MODE_IDLE;
         rsp.status  = ST_IDLE;
         rsp.ignored = 1'b1;
      end else if (req.command == CMD_TIMEOUT) begin
         tmo_cnt_in = tmo_inc;
         if (tmo_inc >= max_timeouts) begin
            mode_in    = MODE_IDLE;
            rsp.status = ST_TOUT;
         end else begin
            rsp.send_kind = SK_RESEND;
         end
      end else if (plen < HEADER_LEN) begin
         rsp.ignored = 1'b1;
      end else if (req.packet_opcode == OP_SRV_ERR) begin
         mode_in               = MODE_IDLE;
         rsp.status            = ST_SERR;
         rsp.server_error_code = req.packet_block;
      end else if (mode_ff == MODE_GET) begin
         if (req.packet_opcode == OP_DATA && req.packet_block == exp_blk_ff) begin
            rsp.store_bytes = (pay > PLEN_W'(STORE_MAX)) ? STORE_MAX : pay[CHUNK_W-1:0];
            rsp.send_kind   = SK_ACK;
            rsp.send_block  = exp_blk_ff;
            tmo_cnt_in      = '0;
            if (pay < PLEN_W'(BLOCK_FULL)) begin
               mode_in    = MODE_IDLE;
               rsp.status = ST_DONE;
            end else begin
               exp_blk_in = exp_next;
            end
         end else begin
            rsp.ignored = 1'b1;
         end
      end else begin
         if (req.packet_opcode == OP_ACK && plen == HEADER_LEN &&
             req.packet_block == exp_blk_ff) begin
            tmo_cnt_in = '0;
            if (last_chunk_ff < BLOCK_FULL) begin
               mode_in    = MODE_IDLE;
               rsp.status = ST_DONE;
            end else begin
               last_chunk_in  = chunk;
               exp_blk_in     = exp_next;
               rsp.send_kind  = SK_DATA;
               rsp.send_block = exp_next;
               rsp.send_bytes = chunk;
            end
         end else begin
            rsp.ignored = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         exp_blk_ff    <= '0;
         tmo_cnt_ff    <= '0;
         last_chunk_ff <= BLOCK_FULL;
      end else if (take) begin
         mode_ff       <= mode_in;
         exp_blk_ff    <= exp_blk_in;
         tmo_cnt_ff    <= tmo_cnt_in;
         last_chunk_ff <= last_chunk_in;
      end
   end

endmodule

### src/tftp_client_transfer_engine_unit.sv
// top level of the tftp client transfer engine: request register, engine, response register
// path: an accepted request passes the input register, then the response register, before rsp_tvalid rises
// throughput: one request per cycle while rsp_tready stays high; the engine state is read and updated in the same cycle
// a full response register with rsp_tready low stalls the input register, then req_tready
// reset: synchronous active high; transfer idle, block 0, timeout count 0, max_timeouts 4
module tftp_client_transfer_engine_unit #(
   parameter int MAX_PACKET = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // packet_length, packet_opcode, packet_block, next_chunk_bytes, zero fill
   input  logic [tftpce_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [tftpce_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // send_block, send_bytes, store_bytes, status, ignored, server_error_code
   output logic [tftpce_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // send_kind
   output logic [tftpce_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                              csr_wr_en,
   input  logic [tftpce_pkg::TMO_W-1:0]      csr_wr_data
);
   import tftpce_pkg::*;

   logic               out_free;
   logic               take;
   req_type            hold_req;
   rsp_type            dec_rsp;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [TMO_W-1:0]   max_tmo_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   tftpce_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_free   (out_free),
      .take       (take),
      .hold_req   (hold_req)
   );

   tftpce_engine #(
      .MAX_PACKET (MAX_PACKET)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .req          (hold_req),
      .max_timeouts (max_tmo_ff),
      .rsp          (dec_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = dec_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_tmo_ff   <= TMO_DEFAULT;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_tmo_ff <= csr_wr_data;
         end
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.send_kind;
   assign rsp_tdata  = {rsp_ff.server_error_code, rsp_ff.ignored, rsp_ff.status,
                        rsp_ff.store_bytes, rsp_ff.send_bytes, rsp_ff.send_block};

   a_ignored_sends_nothing : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ignored |-> rsp_ff.send_kind == SK_NONE)
      else $error("ignored request produced a send");

   a_idle_is_ignored : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_IDLE |-> rsp_ff.ignored)
      else $error("idle status without ignore flag");

   a_error_code_only_on_serr : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.server_error_code != '0 |-> rsp_ff.status == ST_SERR)
      else $error("server error code outside server error status");

   a_bytes_only_on_data : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.send_bytes != '0 |-> rsp_ff.send_kind == SK_DATA)
      else $error("send bytes without data packet");

   a_take_fills_response : assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("taken request did not reach response register");

endmodule

### sim/tb_tftp_client_transfer_engine_unit.sv
// testbench for the tftp client transfer engine: directed cases and random get/put sessions checked against a predictor
`timescale 1ns / 1ps

module tb_tftp_client_transfer_engine_unit;
   import tftpce_pkg::*;

   localparam int PKT_LIMIT = 1024;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [TMO_W-1:0] csr_wr_data = '0;

   tftp_client_transfer_engine_unit #(.MAX_PACKET(PKT_LIMIT)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   req_type pending_events[$];
   rsp_type expected_decisions[$];
   int error_count = 0;
   int rsp_seen = 0;
   bit no_gaps = 1'b0;

   // engine state as the predictor tracks it
   mode_type xfer_mode = MODE_IDLE;
   logic [WORD_W-1:0] want_block = '0;
   logic [TMO_W-1:0] timeout_run = '0;
   logic [CHUNK_W-1:0] prev_chunk = BLOCK_FULL;
   logic [TMO_W-1:0] limit_timeouts = TMO_DEFAULT;

   function automatic rsp_type decide_event(input req_type ev);
      rsp_type d;
      logic [PLEN_W-1:0] len;
      logic [PLEN_W-1:0] pay;
      logic [CHUNK_W-1:0] chunk;
      d = '0;
      d.send_kind = SK_NONE;
      d.status = ST_BUSY;
      len = (ev.packet_length > PKT_LIMIT) ? PLEN_W'(PKT_LIMIT) : ev.packet_length;
      chunk = (ev.next_chunk_bytes > BLOCK_FULL) ? BLOCK_FULL : ev.next_chunk_bytes;
      if (ev.command == CMD_GET) begin
         xfer_mode = MODE_GET;
         want_block = 16'd1;
         timeout_run = '0;
         d.send_kind = SK_RRQ;
      end else if (ev.command == CMD_PUT) begin
         xfer_mode = MODE_PUT;
         want_block = '0;
         prev_chunk = BLOCK_FULL;
         timeout_run = '0;
         d.send_kind = SK_WRQ;
      end else if (xfer_mode == MODE_IDLE) begin
         d.status = ST_IDLE;
         d.ignored = 1'b1;
      end else if (ev.command == CMD_TIMEOUT) begin
         timeout_run = timeout_run + 1'b1;
         if (timeout_run >= limit_timeouts) begin
            xfer_mode = MODE_IDLE;
            d.status = ST_TOUT;
         end else begin
            d.send_kind = SK_RESEND;
         end
      end else if (len < HEADER_LEN) begin
         d.ignored = 1'b1;
      end else if (ev.packet_opcode == OP_SRV_ERR) begin
         xfer_mode = MODE_IDLE;
         d.status = ST_SERR;
         d.server_error_code = ev.packet_block;
      end else if (xfer_mode == MODE_GET) begin
         if (ev.packet_opcode == OP_DATA && ev.packet_block == want_block) begin
            pay = len - HEADER_LEN;
            d.store_bytes = (pay > STORE_MAX) ? STORE_MAX : pay[CHUNK_W-1:0];
            d.send_kind = SK_ACK;
            d.send_block = want_block;
            timeout_run = '0;
            if (pay < PLEN_W'(BLOCK_FULL)) begin
               xfer_mode = MODE_IDLE;
               d.status = ST_DONE;
            end else begin
               want_block = want_block + 1'b1;
            end
         end else begin
            d.ignored = 1'b1;
         end
      end else begin
         if (ev.packet_opcode == OP_ACK && len == HEADER_LEN && ev.packet_block == want_block)
         begin
            timeout_run = '0;
            if (prev_chunk < BLOCK_FULL) begin
               xfer_mode = MODE_IDLE;
               d.status = ST_DONE;
            end else begin
               prev_chunk = chunk;
               want_block = want_block + 1'b1;
               d.send_kind = SK_DATA;
               d.send_block = want_block;
               d.send_bytes = chunk;
            end
         end else begin
            d.ignored = 1'b1;
         end
      end
      return d;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_decisions.push_back(decide_event(pending_events.pop_front()));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_events.size() != 0 && (no_gaps || $urandom_range(99) >= 32)) begin
               req_tvalid <= 1'b1;
               req_tdata <= {3'b000, pending_events[0].next_chunk_bytes,
                             pending_events[0].packet_block, pending_events[0].packet_opcode,
                             pending_events[0].packet_length};
               req_tuser <= pending_events[0].command;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // response monitor with a long hold-off now and then
   int hold_left = 0;
   int next_hold_at = 150;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (expected_decisions.size() == 0) begin
               $display("%0t unexpected response, kind %0d", $time, rsp_tuser);
               error_count++;
            end else begin
               want = expected_decisions.pop_front();
               check_field("send_kind", 16'(want.send_kind), 16'(rsp_tuser));
               check_field("send_block", want.send_block, rsp_tdata[15:0]);
               check_field("send_bytes", 16'(want.send_bytes), 16'(rsp_tdata[25:16]));
               check_field("store_bytes", 16'(want.store_bytes), 16'(rsp_tdata[35:26]));
               check_field("status", 16'(want.status), 16'(rsp_tdata[38:36]));
               check_field("ignored", 16'(want.ignored), 16'(rsp_tdata[39]));
               check_field("server_error_code", want.server_error_code, rsp_tdata[55:40]);
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_seen >= next_hold_at) begin
            hold_left = 80;
            next_hold_at += 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_gaps || ($urandom_range(99) >= 32);
         end
      end
   end

   task automatic push_event(input cmd_type cmd, input int len, input int opc,
                             input int blk, input int chunk);
      req_type ev;
      ev.command = cmd;
      ev.packet_length = PLEN_W'(len);
      ev.packet_opcode = WORD_W'(opc);
      ev.packet_block = WORD_W'(blk);
      ev.next_chunk_bytes = CHUNK_W'(chunk);
      pending_events.push_back(ev);
   endtask

   task automatic push_noise();
      int pick;
      pick = $urandom_range(3);
      push_event(cmd_type'(pick == 0 ? $urandom_range(3) : 2 + (pick & 1)),
                 $urandom_range(2047),
                 $urandom_range(1) ? $urandom_range(65535) : $urandom_range(7),
                 $urandom_range(65535), $urandom_range(1023));
   endtask

   task automatic push_start(input cmd_type cmd);
      push_event(cmd, $urandom_range(2047), $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(1023));
   endtask

   task automatic push_timeout();
      push_event(CMD_TIMEOUT, $urandom_range(2047), $urandom_range(65535),
                 $urandom_range(65535), $urandom_range(1023));
   endtask

   task automatic push_server_error();
      push_event(CMD_PACKET, $urandom_range(4, 2047), OP_SRV_ERR, $urandom_range(65535),
                 $urandom_range(1023));
   endtask

   task automatic run_get(input int nblk);
      int len;
      push_start(CMD_GET);
      for (int b = 1; b <= nblk; b++) begin
         if ($urandom_range(7) == 0) push_timeout();
         if ($urandom_range(9) == 0)
            push_event(CMD_PACKET, 516, OP_DATA, b - 1, $urandom_range(1023));
         if ($urandom_range(29) == 0) begin
            push_server_error();
            return;
         end
         if (b == nblk) len = $urandom_range(4, 515);
         else if ($urandom_range(1)) len = 516;
         else len = $urandom_range(516, 2047);
         push_event(CMD_PACKET, len, OP_DATA, b, $urandom_range(1023));
      end
   endtask

   task automatic run_put(input int nblk);
      int chunk;
      push_start(CMD_PUT);
      for (int b = 0; b <= nblk; b++) begin
         if ($urandom_range(7) == 0) push_timeout();
         if ($urandom_range(9) == 0)
            push_event(CMD_PACKET, $urandom_range(5, 40), OP_ACK, b, $urandom_range(1023));
         if ($urandom_range(29) == 0) begin
            push_server_error();
            return;
         end
         if (b == nblk - 1) chunk = $urandom_range(511);
         else if ($urandom_range(1)) chunk = 512;
         else chunk = $urandom_range(512, 1023);
         push_event(CMD_PACKET, 4, OP_ACK, b, chunk);
      end
   endtask

   task automatic run_sessions(input int count);
      int pick;
      int target;
      target = pending_events.size() + count;
      while (pending_events.size() < target) begin
         pick = $urandom_range(99);
         if (pick < 45) run_get($urandom_range(1, 6));
         else if (pick < 80) run_put($urandom_range(1, 6));
         else repeat ($urandom_range(1, 4)) push_noise();
      end
   endtask

   task automatic drain();
      while (pending_events.size() != 0 || expected_decisions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [TMO_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_timeouts = value;
      @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // events while idle, then a get with short, oversized and duplicate packets
      push_timeout();
      push_event(CMD_PACKET, 516, OP_DATA, 1, 0);
      push_event(CMD_GET, 0, 0, 0, 0);
      push_event(CMD_PACKET, 3, OP_DATA, 1, 0);
      push_event(CMD_PACKET, 2047, OP_DATA, 1, 1023);
      push_event(CMD_PACKET, 516, OP_DATA, 1, 0);
      repeat (3) push_timeout();
      push_event(CMD_PACKET, 516, OP_DATA, 2, 0);
      push_timeout();
      push_event(CMD_PACKET, 4, OP_DATA, 3, 0);
      // put with a bad ack length, an oversized chunk, an empty block and the final ack
      push_event(CMD_PUT, 2047, 65535, 65535, 1023);
      push_event(CMD_PACKET, 5, OP_ACK, 0, 512);
      push_event(CMD_PACKET, 4, OP_ACK, 0, 1023);
      push_event(CMD_PACKET, 4, OP_ACK, 1, 0);
      push_event(CMD_PACKET, 4, OP_ACK, 2, 0);
      // restart while busy, server error, timeout abort
      push_event(CMD_PUT, 0, 0, 0, 0);
      push_event(CMD_GET, 0, 0, 0, 0);
      push_event(CMD_PACKET, 4, OP_SRV_ERR, 65535, 0);
      push_event(CMD_GET, 0, 0, 0, 0);
      repeat (4) push_timeout();

      write_limit(4'd0);
      push_start(CMD_GET);
      push_timeout();
      push_start(CMD_PUT);
      push_event(CMD_PACKET, 4, OP_ACK, 0, 512);
      push_timeout();

      write_limit(4'd15);
      push_start(CMD_GET);
      repeat (15) push_timeout();

      write_limit(4'd1);
      run_sessions(200);

      write_limit(4'd15);
      no_gaps = 1'b1;
      run_sessions(200);
      drain();
      no_gaps = 1'b0;

      write_limit(TMO_W'($urandom_range(2, 14)));
      run_sessions(200);

      write_limit(TMO_W'($urandom_range(1, 15)));
      run_sessions(200);

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
